### src/weighted_neighbor_walk_step_macros.svh
// Assertion macros for the weighted neighbor walk step block.
`ifndef WEIGHTED_NEIGHBOR_WALK_STEP_MACROS_SVH
`define WEIGHTED_NEIGHBOR_WALK_STEP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WNW_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define WNW_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### src/wnws_pkg.sv
// Package: request codes, status codes, field widths.
package wnws_pkg;
   localparam int MaxVertices = 4096;
   localparam int MaxEdges    = 65536;
   localparam int WeightBits  = 16;

   localparam logic [1:0] REQ_SET_OFFSET = 2'd0;
   localparam logic [1:0] REQ_LOAD_EDGE  = 2'd1;
   localparam logic [1:0] REQ_BEGIN_PATH = 2'd2;
   localparam logic [1:0] REQ_WALK_STEP  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_EDGES = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam int ReqTdataBits = 80;
   localparam int RspTdataBits = 112;
endpackage

### src/weighted_neighbor_walk_step.sv
// Top level: graph stores, prefix-sum loader and binary-search walk step.
//
//  channel | dir | transfer when          | payload
//  req_    | in  | req_tvalid & tready    | tdata: vertex,index,neighbor,weight,first,random
//                                          | tuser: req_type
//  rsp_    | out | rsp_tvalid & tready    | tdata: next_vertex,chosen_edge,recip_weight,path_sum
//                                          | tuser: status
//
// Items are handled one at a time. Loads and offset writes go straight to the
// done state; begin path runs the bit-serial reciprocal divider; a walk step
// takes 3 offset/prefix reads, one per-level memory read for each of up to
// log2(MAX_EDGES) search levels, then the divider. Reset clears control and
// both accumulators; the memories hold garbage until written. The result sits
// in an output register; a stalled rsp holds only it.
module weighted_neighbor_walk_step #(
   parameter int MAX_VERTICES = wnws_pkg::MaxVertices,
   parameter int MAX_EDGES    = wnws_pkg::MaxEdges,
   parameter int WEIGHT_BITS  = wnws_pkg::WeightBits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [12:0] vertex, [29:13] index, [41:30] neighbor, [57:42] weight,
   // [58] first_of_vertex, [74:59] random, rest zero
   input  logic [wnws_pkg::ReqTdataBits-1:0] req_tdata,
   input  logic [1:0]   req_tuser,   // [1:0] req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [11:0] next_vertex, [27:12] chosen_edge, [60:28] recip_weight,
   // [108:61] path_sum, rest zero
   output logic [wnws_pkg::RspTdataBits-1:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // [1:0] status
);
   localparam int VA = $clog2(MAX_VERTICES + 1);
   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_OFF0  = 4'd1;
   localparam logic [3:0] ST_OFF1  = 4'd2;
   localparam logic [3:0] ST_LAST  = 4'd3;
   localparam logic [3:0] ST_SRCH  = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_EDGE  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;
   localparam logic [3:0] ST_TGT   = 4'd9;

   // request fields
   logic [12:0] f_vertex;
   logic [16:0] f_index;
   logic [11:0] f_neighbor;
   logic [15:0] f_weight;
   logic        f_first;
   logic [15:0] f_random;
   assign f_vertex   = req_tdata[12:0];
   assign f_index    = req_tdata[29:13];
   assign f_neighbor = req_tdata[41:30];
   assign f_weight   = req_tdata[57:42] & 16'((17'd1 << WEIGHT_BITS) - 17'd1);
   assign f_first    = req_tdata[58];
   assign f_random   = req_tdata[74:59];

   // memories
   logic [16:0] offset_mem   [MAX_VERTICES + 1];
   logic [11:0] neighbor_mem [MAX_EDGES];
   logic [15:0] weight_mem   [MAX_EDGES];
   logic [31:0] prefix_mem   [MAX_EDGES];

   logic [3:0]  state_ff, state_in;
   logic        rsp_valid_ff;
   logic [31:0] load_sum_ff;
   logic [47:0] path_ff;
   logic [12:0] vtx_ff;
   logic [15:0] rnd_ff;
   logic [16:0] lo_ff, hi_ff;
   logic [47:0] target_ff;
   logic [16:0] off_rd_ff;
   logic [31:0] pfx_rd_ff;
   logic [11:0] nb_rd_ff;
   logic [15:0] wt_rd_ff;
   logic [11:0] next_ff;
   logic [15:0] edge_ff;
   logic [32:0] recip_ff;
   logic [1:0]  status_ff;
   logic        walk_ff;

   logic        accept;
   logic [VA-1:0] off_addr;
   logic [EA-1:0] pfx_addr;
   logic [16:0]   mid;
   logic [16:0]   off_clamped;
   logic          div_start;
   logic [23:0]   div_value;
   logic          div_done;
   logic [32:0]   div_q;
   logic [32:0]   load_sum_wide;
   logic [31:0]   load_sum_new;
   logic [48:0]   path_wide;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign mid        = 17'((18'(lo_ff) + 18'(hi_ff)) >> 1);
   // edge range bound clamped to the store size
   assign off_clamped = (off_rd_ff > 17'(MAX_EDGES)) ? 17'(MAX_EDGES) : off_rd_ff;

   // offset read address: vertex, then vertex+1
   always_comb begin
      if (state_ff == ST_OFF0) off_addr = VA'(vtx_ff + 13'd1);
      else off_addr = VA'(f_vertex);
   end

   // prefix read address: last edge, then search midpoint, then final edge
   always_comb begin
      if (state_ff == ST_SRCH) pfx_addr = EA'(mid);
      else pfx_addr = EA'(hi_ff);
   end

   assign load_sum_wide = f_first ? 33'(f_weight) : (33'(load_sum_ff) + 33'(f_weight));
   assign load_sum_new  = load_sum_wide[32] ? 32'hFFFF_FFFF : load_sum_wide[31:0];
   assign path_wide     = 49'(path_ff) + 49'(div_q);

   always_ff @(posedge clock) begin
      if (accept && req_tuser == wnws_pkg::REQ_SET_OFFSET && f_vertex <= 13'(MAX_VERTICES))
         offset_mem[VA'(f_vertex)] <= f_index;
      if (accept && req_tuser == wnws_pkg::REQ_LOAD_EDGE && f_index < 17'(MAX_EDGES)) begin
         neighbor_mem[EA'(f_index)] <= f_neighbor;
         weight_mem[EA'(f_index)]   <= f_weight;
         prefix_mem[EA'(f_index)]   <= load_sum_new;
      end
      off_rd_ff <= offset_mem[off_addr];
      pfx_rd_ff <= prefix_mem[pfx_addr];
      nb_rd_ff  <= neighbor_mem[EA'(lo_ff)];
      wt_rd_ff  <= weight_mem[EA'(lo_ff)];
   end

   assign div_start = (state_ff == ST_IDLE && accept && req_tuser == wnws_pkg::REQ_BEGIN_PATH)
                      || (state_ff == ST_EDGE);
   assign div_value = (state_ff == ST_EDGE) ? 24'(wt_rd_ff) : 24'(f_weight);

   wnws_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_value),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  wnws_pkg::REQ_BEGIN_PATH: state_in = ST_DIV;
                  wnws_pkg::REQ_WALK_STEP:
                     state_in = (f_vertex >= 13'(MAX_VERTICES)) ? ST_DONE : ST_OFF0;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_OFF0: state_in = ST_OFF1;
         ST_OFF1: state_in = ST_LAST;
         ST_LAST: state_in = (status_ff == wnws_pkg::STATUS_NO_EDGES) ? ST_DONE : ST_TGT;
         ST_TGT:  state_in = ST_SRCH;
         ST_SRCH: state_in = (lo_ff < hi_ff) ? ST_CMP : ST_EDGE;
         ST_CMP:  state_in = ST_SRCH;
         ST_EDGE: state_in = ST_DIV;
         ST_DIV:  state_in = div_done ? ST_DONE : ST_DIV;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         load_sum_ff  <= '0;
         path_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         if (accept && req_tuser == wnws_pkg::REQ_LOAD_EDGE && f_index < 17'(MAX_EDGES))
            load_sum_ff <= load_sum_new;
         if (state_ff == ST_DIV && div_done) begin
            if (walk_ff) path_ff <= path_wide[48] ? 48'hFFFF_FFFF_FFFF : path_wide[47:0];
            else path_ff <= 48'(div_q);
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (accept) begin
            vtx_ff    <= f_vertex;
            rnd_ff    <= f_random;
            next_ff   <= '0;
            edge_ff   <= '0;
            recip_ff  <= '0;
            walk_ff   <= (req_tuser == wnws_pkg::REQ_WALK_STEP);
            status_ff <= wnws_pkg::STATUS_OK;
            if ((req_tuser == wnws_pkg::REQ_SET_OFFSET && f_vertex > 13'(MAX_VERTICES))
                || (req_tuser == wnws_pkg::REQ_LOAD_EDGE && f_index >= 17'(MAX_EDGES))
                || (req_tuser == wnws_pkg::REQ_WALK_STEP && f_vertex >= 13'(MAX_VERTICES)))
               status_ff <= wnws_pkg::STATUS_RANGE;
         end
         // offset of vertex arrives here, offset of vertex+1 in the cycle after
         ST_OFF0: lo_ff <= off_clamped;
         ST_OFF1: begin
            if (off_clamped <= lo_ff) status_ff <= wnws_pkg::STATUS_NO_EDGES;
            else hi_ff <= off_clamped - 17'd1;
         end
         ST_LAST: ;
         ST_TGT: ;
         ST_SRCH: if (lo_ff == hi_ff || !(lo_ff < hi_ff))
                     target_ff <= target_ff;
         ST_CMP: begin
            if ({pfx_rd_ff, 16'd0} >= target_ff) hi_ff <= mid;
            else lo_ff <= mid + 17'd1;
         end
         ST_EDGE: begin
            next_ff <= nb_rd_ff;
            edge_ff <= lo_ff[15:0];
         end
         ST_DIV: if (div_done) recip_ff <= div_q;
         default: ;
      endcase
      // prefix of last edge arrives in ST_TGT, the cycle after ST_LAST issues the read
      if (state_ff == ST_TGT) target_ff <= 48'(rnd_ff) * 48'(pfx_rd_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'd0, path_ff, recip_ff, edge_ff, next_ff};

   `include "weighted_neighbor_walk_step_macros.svh"
   `WNW_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready)
   `WNW_ASSERT_NEXT(a_done_gives_rsp, clock, reset, state_ff == ST_DONE, rsp_tvalid)
   `WNW_ASSERT_IMP(a_search_order, clock, reset, state_ff == ST_CMP, lo_ff < hi_ff)
endmodule

### src/wnws_recip.sv
// Restoring divider computing floor(2^32 / w), or 2^32 for w = 0, one quotient bit per cycle.
module wnws_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [23:0] div_ff, div_in;
   logic [25:0] trial;
   logic        dividend_bit;

   // dividend is 2^32: a one at bit 32 only
   always_comb begin
      dividend_bit = (count_ff == 6'd32);
      trial = {rem_ff, dividend_bit} - {2'b00, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd32;
         rem_in   = '0;
         quo_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (div_ff == '0) begin
            quo_in  = 33'h1_0000_0000;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (!trial[25]) begin
               rem_in = trial[24:0];
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = {rem_ff[23:0], dividend_bit};
               quo_in = {quo_ff[31:0], 1'b0};
            end
            if (count_ff == 6'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               count_in = count_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### bench/weighted_neighbor_walk_step_checker.sv
// Checker: watches both channels, predicts each result and compares it.
module weighted_neighbor_walk_step_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [79:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);
   typedef struct packed {
      logic [11:0] next_vertex;
      logic [15:0] chosen_edge;
      logic [32:0] recip_weight;
      logic [47:0] path_sum;
      logic [1:0]  status;
   } walk_result_type;

   walk_result_type step_results_q[$];

   logic [16:0] offsets   [0:wnws_pkg::MaxVertices];
   logic [11:0] neighbors [0:wnws_pkg::MaxEdges-1];
   logic [15:0] weights   [0:wnws_pkg::MaxEdges-1];
   logic [31:0] prefixes  [0:wnws_pkg::MaxEdges-1];
   logic [31:0] running_sum;
   logic [47:0] path_acc;

   function automatic logic [32:0] reciprocal(input logic [15:0] w);
      if (w == 16'd0) return 33'h1_0000_0000;
      return 33'h1_0000_0000 / {17'd0, w};
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", field, got, want);
      fail_count++;
   endtask

   task automatic predict_transfer(input logic [1:0] kind, input logic [79:0] d);
      logic [12:0] vertex;
      logic [16:0] index;
      logic [11:0] nb;
      logic [15:0] weight;
      logic        first;
      logic [15:0] rnd;
      logic [32:0] sum;
      logic [16:0] lo, span_end, hi, mid;
      logic [47:0] target;
      logic [48:0] acc;
      walk_result_type r;
      vertex = d[12:0];
      index  = d[29:13];
      nb     = d[41:30];
      weight = d[57:42];
      first  = d[58];
      rnd    = d[74:59];
      r = '0;
      r.status = wnws_pkg::STATUS_OK;
      case (kind)
         wnws_pkg::REQ_SET_OFFSET: begin
            if (vertex <= wnws_pkg::MaxVertices) offsets[vertex] = index;
            else r.status = wnws_pkg::STATUS_RANGE;
         end
         wnws_pkg::REQ_LOAD_EDGE: begin
            if (index < wnws_pkg::MaxEdges) begin
               sum = first ? {17'd0, weight} : {1'b0, running_sum} + weight;
               if (sum[32]) sum = 33'h0_FFFF_FFFF;
               running_sum = sum[31:0];
               neighbors[index] = nb;
               weights[index]   = weight;
               prefixes[index]  = sum[31:0];
            end else begin
               r.status = wnws_pkg::STATUS_RANGE;
            end
         end
         wnws_pkg::REQ_BEGIN_PATH: begin
            r.recip_weight = reciprocal(weight);
            path_acc = {15'd0, r.recip_weight};
         end
         default: begin
            if (vertex >= wnws_pkg::MaxVertices) begin
               r.status = wnws_pkg::STATUS_RANGE;
            end else begin
               lo       = offsets[vertex];
               span_end = offsets[vertex + 1];
               if (lo > wnws_pkg::MaxEdges) lo = wnws_pkg::MaxEdges;
               if (span_end > wnws_pkg::MaxEdges) span_end = wnws_pkg::MaxEdges;
               if (span_end <= lo) begin
                  r.status = wnws_pkg::STATUS_NO_EDGES;
               end else begin
                  // lower-bound search for the first prefix reaching rnd/2^16 of the total
                  hi = span_end - 1;
                  target = rnd * prefixes[hi];
                  while (lo < hi) begin
                     mid = (lo + hi) >> 1;
                     if ({prefixes[mid], 16'd0} >= target) hi = mid;
                     else lo = mid + 1;
                  end
                  r.chosen_edge  = lo[15:0];
                  r.next_vertex  = neighbors[lo];
                  r.recip_weight = reciprocal(weights[lo]);
                  acc = {1'b0, path_acc} + r.recip_weight;
                  path_acc = acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0];
               end
            end
         end
      endcase
      r.path_sum = path_acc;
      step_results_q = {step_results_q, r};
   endtask

   always @(posedge clock) begin
      walk_result_type e;
      if (reset) begin
         running_sum = '0;
         path_acc    = '0;
         fail_count  = 0;
         step_results_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (step_results_q.size() == 0) begin
               report("unexpected result", rsp_tdata[63:0], 64'd0);
            end else begin
               e = step_results_q.pop_front();
               if (rsp_tdata[11:0] !== e.next_vertex)
                  report("next_vertex", rsp_tdata[11:0], e.next_vertex);
               if (rsp_tdata[27:12] !== e.chosen_edge)
                  report("chosen_edge", rsp_tdata[27:12], e.chosen_edge);
               if (rsp_tdata[60:28] !== e.recip_weight)
                  report("recip_weight", rsp_tdata[60:28], e.recip_weight);
               if (rsp_tdata[108:61] !== e.path_sum)
                  report("path_sum", rsp_tdata[108:61], e.path_sum);
               if (rsp_tuser !== e.status)
                  report("status", rsp_tuser, e.status);
            end
         end
         if (req_tvalid && req_tready) predict_transfer(req_tuser, req_tdata);
      end
      pending = step_results_q.size();
   end
endmodule

### bench/weighted_neighbor_walk_step_tb.sv
// Testbench top: clock, reset, graph-building stimulus, rsp backpressure, verdict.
module weighted_neighbor_walk_step_tb;
   localparam int StallLimit = 2000;   // idle cycles before the watchdog fires
   localparam int ItemGoal   = 1650;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;   // vertex, index, neighbor, weight, first, random
   logic [1:0]   req_tuser = '0;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;        // next_vertex, chosen_edge, recip_weight, path_sum
   logic [1:0]   rsp_tuser;        // status
   int           fail_count;
   int           pending;

   // legality tracking: walks only read offsets and edges written before
   bit          offset_set [0:wnws_pkg::MaxVertices];
   logic [16:0] offset_val [0:wnws_pkg::MaxVertices];
   bit          edge_set   [0:wnws_pkg::MaxEdges-1];
   int          built_q[$];
   int          items_sent = 0;
   bit          quiet = 1'b0;      // when set, neither side idles
   int          rsp_hold = 0;
   int          idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   weighted_neighbor_walk_step u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   weighted_neighbor_walk_step_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .fail_count, .pending
   );

   // result side: random stall after every transfer, none while quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_hold = quiet ? 0 : $urandom_range(0, 19);
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= (rsp_hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: counts cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else if (++idle_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send(input logic [1:0] kind, input int vertex, input int index,
                       input int nb, input int weight, input bit first, input int rnd);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, rnd[15:0], first, weight[15:0], nb[11:0], index[16:0], vertex[12:0]};
      do @(posedge clock); while (!req_tready);
      if (kind == wnws_pkg::REQ_SET_OFFSET && vertex <= wnws_pkg::MaxVertices) begin
         offset_set[vertex] = 1'b1;
         offset_val[vertex] = index[16:0];
      end
      if (kind == wnws_pkg::REQ_LOAD_EDGE && index < wnws_pkg::MaxEdges) edge_set[index] = 1'b1;
      items_sent++;
      if (items_sent % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
   endtask

   function automatic bit walk_is_legal(input int v);
      int lo, hi;
      if (v >= wnws_pkg::MaxVertices) return 1'b1;
      if (!offset_set[v] || !offset_set[v + 1]) return 1'b0;
      lo = (offset_val[v] > wnws_pkg::MaxEdges) ? wnws_pkg::MaxEdges : offset_val[v];
      hi = (offset_val[v + 1] > wnws_pkg::MaxEdges) ? wnws_pkg::MaxEdges : offset_val[v + 1];
      if (hi <= lo) return 1'b1;
      if (hi - lo > 256) return 1'b0;
      for (int i = lo; i < hi; i++) if (!edge_set[i]) return 1'b0;
      return 1'b1;
   endfunction

   // one vertex with n consecutive edges starting at slot base
   task automatic build_vertex(input int v, input int base, input int n);
      send(wnws_pkg::REQ_SET_OFFSET, v, base, 0, 1, 0, 0);
      send(wnws_pkg::REQ_SET_OFFSET, v + 1, base + n, 0, 1, 0, 0);
      for (int i = 0; i < n; i++)
         send(wnws_pkg::REQ_LOAD_EDGE, $urandom_range(0, 8191), base + i,
              $urandom_range(0, 4095), $urandom_range(1, 65535), i == 0,
              $urandom_range(0, 65535));
      built_q = {built_q, v};
   endtask

   initial begin
      int r, v, n, base;
      req_tvalid <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: heavy, light and zero-weight edges on vertex 0
      send(wnws_pkg::REQ_SET_OFFSET, 0, 0, 0, 1, 0, 0);
      send(wnws_pkg::REQ_SET_OFFSET, 1, 3, 0, 1, 0, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 0, 4095, 65535, 1, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 1, 0, 1, 0, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 2, 1234, 0, 0, 0);
      send(wnws_pkg::REQ_BEGIN_PATH, 0, 0, 0, 0, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 0, 0, 0, 0, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 0, 0, 0, 0, 0, 65535);
      send(wnws_pkg::REQ_BEGIN_PATH, 0, 0, 0, 1, 0, 0);
      send(wnws_pkg::REQ_BEGIN_PATH, 0, 0, 0, 65535, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 0, 0, 0, 0, 0, 32768);
      // empty and inverted ranges
      send(wnws_pkg::REQ_SET_OFFSET, 2, 3, 0, 1, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 1, 0, 0, 0, 0, 100);
      send(wnws_pkg::REQ_SET_OFFSET, 3, 1, 0, 1, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 2, 0, 0, 0, 0, 100);
      // out of range vertex and slot
      send(wnws_pkg::REQ_SET_OFFSET, 4097, 5, 0, 1, 0, 0);
      send(wnws_pkg::REQ_SET_OFFSET, 8191, 131071, 0, 1, 0, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 65536, 7, 9, 1, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 8191, 131071, 4095, 65535, 1, 65535);
      send(wnws_pkg::REQ_WALK_STEP, 4096, 0, 0, 0, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 8191, 131071, 4095, 65535, 1, 65535);
      // offsets past the edge store are clamped
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 65534, 4095, 300, 1, 0);
      send(wnws_pkg::REQ_LOAD_EDGE, 0, 65535, 17, 5, 0, 0);
      send(wnws_pkg::REQ_SET_OFFSET, 10, 65534, 0, 1, 0, 0);
      send(wnws_pkg::REQ_SET_OFFSET, 11, 131071, 0, 1, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 10, 0, 0, 0, 0, 65535);
      send(wnws_pkg::REQ_SET_OFFSET, 12, 100000, 0, 1, 0, 0);
      send(wnws_pkg::REQ_WALK_STEP, 11, 0, 0, 0, 0, 1);

      // random: mostly built vertices walked with random fractions
      while (items_sent < ItemGoal) begin
         r = $urandom_range(0, 99);
         if (r < 15 || built_q.size() == 0) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 31);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            base = ($urandom_range(0, 7) == 0)
                   ? $urandom_range(65520, wnws_pkg::MaxEdges - n)
                   : $urandom_range(0, 2000);
            build_vertex(v, base, n);
         end else if (r < 25) begin
            send(wnws_pkg::REQ_BEGIN_PATH, $urandom_range(0, 8191), $urandom_range(0, 131071),
                 $urandom_range(0, 4095), $urandom_range(1, 65535), $urandom_range(0, 1),
                 $urandom_range(0, 65535));
         end else if (r < 88) begin
            v = built_q[$urandom_range(0, built_q.size() - 1)];
            if (!walk_is_legal(v)) v = $urandom_range(wnws_pkg::MaxVertices, 8191);
            send(wnws_pkg::REQ_WALK_STEP, v, $urandom_range(0, 131071),
                 $urandom_range(0, 4095), $urandom_range(1, 65535), $urandom_range(0, 1),
                 $urandom_range(0, 65535));
         end else begin
            case ($urandom_range(0, 3))
               0: send(wnws_pkg::REQ_SET_OFFSET,
                       $urandom_range(wnws_pkg::MaxVertices + 1, 8191),
                       $urandom_range(0, 131071), 0, 1, 0, 0);
               1: send(wnws_pkg::REQ_LOAD_EDGE, 0,
                       $urandom_range(wnws_pkg::MaxEdges, 131071),
                       $urandom_range(0, 4095), $urandom_range(1, 65535), 1, 0);
               2: send(wnws_pkg::REQ_WALK_STEP, $urandom_range(wnws_pkg::MaxVertices, 8191),
                       0, 0, 1, 0, $urandom_range(0, 65535));
               default: send(wnws_pkg::REQ_LOAD_EDGE, 0, $urandom_range(0, 2000),
                       $urandom_range(0, 4095), $urandom_range(1, 65535),
                       $urandom_range(0, 1), 0);
            endcase
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
